// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the framer modules. Each macro expects the
// module to have clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define J1708_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("j1708 framer: property failed");

// condition must never be seen at a clock edge outside reset
`define J1708_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("j1708 framer: forbidden condition");

`endif

// ----- rtl/core/j1708mf_pkg.sv -----
// ----------------------------------------------------------------------------
// j1708mf_pkg
// Types, codes and sizes shared by the J1708 message framer modules.
// ----------------------------------------------------------------------------
package j1708mf_pkg;

  // sizes
  localparam int unsigned TIME_BITS     = 48;
  localparam int unsigned MAX_LEN       = 256;
  localparam int unsigned LEN_BITS      = $clog2(MAX_LEN + 1);
  localparam int unsigned BW_BITS       = 32;
  localparam int unsigned MB_BITS       = 8;
  localparam int unsigned APB_ADDR_BITS = 3;
  localparam int unsigned APB_DATA_BITS = 32;
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_BITS     = $clog2(QUEUE_DEPTH);

  // threshold widths: ceil((break + 1) * bw / 256) and ceil(12 * bw / 256)
  localparam int unsigned MULT_BITS = MB_BITS + 1 + BW_BITS;
  localparam int unsigned THR_BITS  = MULT_BITS + 1 - 8;
  localparam int unsigned BAV_BITS  = BW_BITS + 4 + 1 - 8;

  localparam logic [MB_BITS-1:0] MB_RESET = 8'd2;

  // register indexes
  localparam logic REG_BIT_WIDTH     = 1'b0;
  localparam logic REG_MESSAGE_BREAK = 1'b1;

  // event opcodes
  localparam logic [2:0] OP_START_BIT = 3'd0;
  localparam logic [2:0] OP_DATA      = 3'd1;
  localparam logic [2:0] OP_STOP_BIT  = 3'd2;
  localparam logic [2:0] OP_IDLE      = 3'd3;
  localparam logic [2:0] OP_END       = 3'd5;

  typedef enum logic [1:0] {
    PH_WAIT_START,
    PH_WAIT_DATA,
    PH_WAIT_STOP
  } phase_e;

  typedef enum logic [2:0] {
    KIND_BYTE         = 3'd0,
    KIND_VALID        = 3'd1,
    KIND_CHECKSUM_ERR = 3'd2,
    KIND_TOO_SHORT    = 3'd3,
    KIND_GAP          = 3'd4
  } kind_e;

  // event class after decode
  typedef enum logic [2:0] {
    CLS_START,
    CLS_DATA,
    CLS_STOP,
    CLS_IDLE,
    CLS_END
  } cls_e;

  typedef struct packed {
    logic [2:0]           opcode;
    logic [TIME_BITS-1:0] start_time;
    logic [TIME_BITS-1:0] end_time;
    logic [7:0]           data_byte;
    logic                 direction;
  } in_item_t;

  typedef struct packed {
    kind_e                kind;
    logic [7:0]           byte_value;
    logic [7:0]           byte_index;
    logic [7:0]           msg_id;
    logic [7:0]           received_check;
    logic [7:0]           computed_check;
    logic [LEN_BITS-1:0]  msg_length;
    logic [TIME_BITS-1:0] span_start;
    logic [TIME_BITS-1:0] span_end;
    logic [TIME_BITS-1:0] gap_samples;
    logic                 bus_access_violation;
    logic                 last;
  } out_item_t;

  // decoded event passed from front to back
  typedef struct packed {
    cls_e                 cls;
    logic [TIME_BITS-1:0] stamp;
    logic [7:0]           data_byte;
  } cmd_t;

  // gap thresholds derived from the registers
  typedef struct packed {
    logic                enable;
    logic [THR_BITS-1:0] brk_thr;
    logic [BAV_BITS-1:0] bav_thr;
  } gap_cfg_t;

endpackage

// ----- rtl/core/j1708mf_regs.sv -----
// ----------------------------------------------------------------------------
// j1708mf_regs
// APB register file with the bit width and message break registers, and
// registered gap thresholds derived from them.
// ----------------------------------------------------------------------------
module j1708mf_regs
  import j1708mf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output gap_cfg_t                 gap_cfg_o
);

  logic [BW_BITS-1:0]   bw_q, bw_d;
  logic [MB_BITS-1:0]   mb_q, mb_d;
  logic                 wr_en;
  logic                 reg_sel;
  logic [MB_BITS:0]     mb_plus1;
  logic [MULT_BITS-1:0] brk_prod;
  logic [MULT_BITS:0]   brk_round;
  logic [BW_BITS+3:0]   bw_x12;
  logic [BW_BITS+4:0]   bav_round;
  gap_cfg_t             gap_cfg_q, gap_cfg_d;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  // register writes
  always_comb begin
    bw_d = bw_q;
    mb_d = mb_q;
    if (wr_en) begin
      unique case (reg_sel)
        REG_BIT_WIDTH:     bw_d = pwdata[BW_BITS-1:0];
        REG_MESSAGE_BREAK: mb_d = pwdata[MB_BITS-1:0];
        default:           bw_d = bw_q;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_BIT_WIDTH:     prdata = APB_DATA_BITS'(bw_q);
      REG_MESSAGE_BREAK: prdata = APB_DATA_BITS'(mb_q);
      default:           prdata = '0;
    endcase
  end

  // break threshold: ceil((break + 1) * bw / 256)
  assign mb_plus1  = {1'b0, mb_q} + (MB_BITS + 1)'(1);
  assign brk_prod  = MULT_BITS'(mb_plus1) * MULT_BITS'(bw_q);
  assign brk_round = {1'b0, brk_prod} + (MULT_BITS + 1)'(255);

  // bus access threshold: ceil(12 * bw / 256)
  assign bw_x12    = {1'b0, bw_q, 3'b000} + {2'b00, bw_q, 2'b00};
  assign bav_round = {1'b0, bw_x12} + (BW_BITS + 5)'(255);

  always_comb begin
    gap_cfg_d.enable  = (bw_q != '0);
    gap_cfg_d.brk_thr = brk_round[MULT_BITS:8];
    gap_cfg_d.bav_thr = bav_round[BW_BITS+4:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q      <= '0;
      mb_q      <= MB_RESET;
      gap_cfg_q <= '0;
    end else begin
      bw_q      <= bw_d;
      mb_q      <= mb_d;
      gap_cfg_q <= gap_cfg_d;
    end
  end

  assign gap_cfg_o = gap_cfg_q;

endmodule

// ----- rtl/core/j1708mf_front.sv -----
// ----------------------------------------------------------------------------
// j1708mf_front
// Input stage: accepts receiver events, drops those that never matter
// (transmit data, ignored opcodes) and hands decoded events to the queue.
// ----------------------------------------------------------------------------
module j1708mf_front
  import j1708mf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     q_push_o,
  output cmd_t     q_data_o,
  input  logic     q_full_i
);

  logic f_valid_q, f_valid_d;
  cmd_t f_cmd_q, f_cmd_d;
  logic accept;
  logic keep;
  cls_e cls;

  assign in_stall_o = f_valid_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign q_push_o   = f_valid_q && !q_full_i;
  assign q_data_o   = f_cmd_q;

  // decode the opcode
  always_comb begin
    keep = 1'b1;
    cls  = CLS_IDLE;
    unique case (in_data_i.opcode)
      OP_START_BIT: cls = CLS_START;
      OP_DATA: begin
        cls  = CLS_DATA;
        keep = !in_data_i.direction;
      end
      OP_STOP_BIT:  cls = CLS_STOP;
      OP_IDLE:      cls = CLS_IDLE;
      OP_END:       cls = CLS_END;
      default:      keep = 1'b0;
    endcase
  end

  // holding register in front of the queue
  always_comb begin
    f_valid_d = f_valid_q;
    f_cmd_d   = f_cmd_q;
    if (q_push_o) begin
      f_valid_d = 1'b0;
    end
    if (accept) begin
      f_valid_d         = keep;
      f_cmd_d.cls       = cls;
      f_cmd_d.stamp     = (cls == CLS_STOP) ? in_data_i.end_time : in_data_i.start_time;
      f_cmd_d.data_byte = in_data_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else begin
      f_valid_q <= f_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_cmd_q <= f_cmd_d;
  end

endmodule

// ----- rtl/core/j1708mf_queue.sv -----
// ----------------------------------------------------------------------------
// j1708mf_queue
// Short FIFO of decoded events between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module j1708mf_queue
  import j1708mf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t pop_data_o,
  output logic empty_o
);

  cmd_t                 slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_BITS:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = slot_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPTR_BITS'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + (QPTR_BITS + 1)'(1);
      2'b01:   cnt_d = cnt_q - (QPTR_BITS + 1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  `J1708_NEVER(a_queue_overfill, cnt_q > (QPTR_BITS + 1)'(QUEUE_DEPTH))
  `J1708_ASSERT(a_queue_pop_nonempty, pop_i |-> !empty_o)

endmodule

// ----- rtl/core/j1708mf_back.sv -----
// ----------------------------------------------------------------------------
// j1708mf_back
// Framing engine: phase machine, message state, verdicts and gap reports,
// with an output register and a second slot for the two-result case.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module j1708mf_back
  import j1708mf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gap_cfg_t  gap_cfg_i,
  input  logic      q_valid_i,
  input  cmd_t      q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  phase_e               phase_q, phase_d;
  logic [TIME_BITS-1:0] fs_q, fs_d;
  logic [TIME_BITS-1:0] ps_q, ps_d;
  logic [TIME_BITS-1:0] lv_q, lv_d;
  logic                 fs_ok_q, fs_ok_d;
  logic                 ps_ok_q, ps_ok_d;
  logic                 lv_ok_q, lv_ok_d;
  logic [LEN_BITS-1:0]  cnt_q, cnt_d;
  logic [7:0]           sum_q, sum_d;
  logic [7:0]           first_q, first_d;
  logic [7:0]           last_q, last_d;

  out_item_t out_q, pend_q;
  logic      out_valid_q, pend_valid_q;
  logic      out_free;
  logic      take;

  logic [TIME_BITS-1:0] gap_ps, gap_lv, gap_sel, lv_sel;
  logic                 ge_ps, ge_lv, bav_ps, bav_lv;
  logic                 msg_break, has_bytes, flushing, gap_hit;
  logic [7:0]           calc;
  out_item_t            flush_res, byte_res, gap_res;
  out_item_t            r0, r1;
  logic                 r0_v, r1_v;
  cmd_t                 cmd;

  assign cmd      = q_data_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign take     = q_valid_i && out_free && !pend_valid_q;
  assign q_pop_o  = take;

  // gap measurements from the last stop bit and from the last message end
  assign gap_ps = cmd.stamp - ps_q;
  assign gap_lv = cmd.stamp - lv_q;
  assign ge_ps  = gap_ps >= TIME_BITS'(gap_cfg_i.brk_thr);
  assign ge_lv  = gap_lv >= TIME_BITS'(gap_cfg_i.brk_thr);
  assign bav_ps = gap_ps < TIME_BITS'(gap_cfg_i.bav_thr);
  assign bav_lv = gap_lv < TIME_BITS'(gap_cfg_i.bav_thr);

  assign msg_break = ps_ok_q && gap_cfg_i.enable && ge_ps;
  assign has_bytes = (cnt_q != '0);
  assign flushing  = fs_ok_q && msg_break && has_bytes;

  // a message closed by this start bit becomes the reference for the gap
  assign lv_sel  = flushing ? ps_q : lv_q;
  assign gap_sel = flushing ? gap_ps : gap_lv;
  assign gap_hit = flushing || (lv_ok_q && gap_cfg_i.enable && ge_lv);

  // checksum over all bytes but the last
  assign calc = 8'h00 - (sum_q - last_q);

  // verdict for a closing message
  always_comb begin
    flush_res            = '0;
    flush_res.msg_id     = first_q;
    flush_res.msg_length = cnt_q;
    flush_res.span_start = fs_q;
    flush_res.span_end   = ps_q;
    if (cnt_q < LEN_BITS'(2)) begin
      flush_res.kind = KIND_TOO_SHORT;
    end else begin
      flush_res.kind           = (calc == last_q) ? KIND_VALID : KIND_CHECKSUM_ERR;
      flush_res.received_check = last_q;
      flush_res.computed_check = calc;
    end
  end

  // echo of a stored byte
  always_comb begin
    byte_res            = '0;
    byte_res.kind       = KIND_BYTE;
    byte_res.byte_value = cmd.data_byte;
    byte_res.byte_index = cnt_q[7:0];
    byte_res.msg_id     = has_bytes ? first_q : cmd.data_byte;
    byte_res.msg_length = cnt_q + LEN_BITS'(1);
  end

  // inter-message gap report
  always_comb begin
    gap_res                      = '0;
    gap_res.kind                 = KIND_GAP;
    gap_res.span_start           = lv_sel;
    gap_res.span_end             = cmd.stamp;
    gap_res.gap_samples          = gap_sel;
    gap_res.bus_access_violation = flushing ? bav_ps : bav_lv;
  end

  // phase machine: next state
  always_comb begin
    phase_d = phase_q;
    if (take) begin
      unique case (cmd.cls)
        CLS_END:   if (has_bytes) phase_d = PH_WAIT_START;
        CLS_START: if (phase_q == PH_WAIT_START) phase_d = PH_WAIT_DATA;
        CLS_DATA:  if (phase_q == PH_WAIT_DATA) phase_d = PH_WAIT_STOP;
        CLS_STOP:  if (phase_q == PH_WAIT_STOP) phase_d = PH_WAIT_START;
        CLS_IDLE:  phase_d = phase_q;
        default:   phase_d = phase_q;
      endcase
    end
  end

  // phase machine: message state and results
  always_comb begin
    fs_d    = fs_q;
    fs_ok_d = fs_ok_q;
    ps_d    = ps_q;
    ps_ok_d = ps_ok_q;
    lv_d    = lv_q;
    lv_ok_d = lv_ok_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    first_d = first_q;
    last_d  = last_q;
    r0      = '0;
    r1      = '0;
    r0_v    = 1'b0;
    r1_v    = 1'b0;
    if (take) begin
      unique case (cmd.cls)
        CLS_END: begin
          if (has_bytes) begin
            r0      = flush_res;
            r0_v    = 1'b1;
            lv_d    = ps_q;
            lv_ok_d = ps_ok_q;
            fs_d    = '0;
            fs_ok_d = 1'b0;
            ps_d    = '0;
            ps_ok_d = 1'b0;
            cnt_d   = '0;
            sum_d   = '0;
            first_d = '0;
            last_d  = '0;
          end
        end
        CLS_START: begin
          if (phase_q == PH_WAIT_START) begin
            if (!fs_ok_q) begin
              fs_d    = cmd.stamp;
              fs_ok_d = 1'b1;
            end else if (msg_break) begin
              if (has_bytes) begin
                r0      = flush_res;
                r0_v    = 1'b1;
                lv_d    = ps_q;
                lv_ok_d = 1'b1;
              end
              fs_d    = '0;
              fs_ok_d = 1'b0;
              ps_d    = '0;
              ps_ok_d = 1'b0;
              cnt_d   = '0;
              sum_d   = '0;
              first_d = '0;
              last_d  = '0;
            end
            // gap report restarts the message at this start bit
            if (gap_hit) begin
              lv_d    = '0;
              lv_ok_d = 1'b0;
              fs_d    = cmd.stamp;
              fs_ok_d = 1'b1;
              if (r0_v) begin
                r1   = gap_res;
                r1_v = 1'b1;
              end else begin
                r0   = gap_res;
                r0_v = 1'b1;
              end
            end
          end
        end
        CLS_IDLE: begin
          if (phase_q == PH_WAIT_START && msg_break) begin
            if (has_bytes) begin
              r0      = flush_res;
              r0_v    = 1'b1;
              lv_d    = ps_q;
              lv_ok_d = 1'b1;
            end
            fs_d    = '0;
            fs_ok_d = 1'b0;
            ps_d    = '0;
            ps_ok_d = 1'b0;
            cnt_d   = '0;
            sum_d   = '0;
            first_d = '0;
            last_d  = '0;
          end
        end
        CLS_DATA: begin
          // bytes past the length limit are dropped silently
          if (phase_q == PH_WAIT_DATA && cnt_q < LEN_BITS'(MAX_LEN)) begin
            if (!has_bytes) begin
              first_d = cmd.data_byte;
            end
            last_d = cmd.data_byte;
            sum_d  = sum_q + cmd.data_byte;
            cnt_d  = cnt_q + LEN_BITS'(1);
            r0     = byte_res;
            r0_v   = 1'b1;
          end
        end
        CLS_STOP: begin
          if (phase_q == PH_WAIT_STOP) begin
            ps_d    = cmd.stamp;
            ps_ok_d = 1'b1;
          end
        end
        default: begin
          r0_v = 1'b0;
        end
      endcase
    end
    r0.last = !r1_v;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_START;
      fs_q    <= '0;
      fs_ok_q <= 1'b0;
      ps_q    <= '0;
      ps_ok_q <= 1'b0;
      lv_q    <= '0;
      lv_ok_q <= 1'b0;
      cnt_q   <= '0;
      sum_q   <= '0;
      first_q <= '0;
      last_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fs_q    <= fs_d;
      fs_ok_q <= fs_ok_d;
      ps_q    <= ps_d;
      ps_ok_q <= ps_ok_d;
      lv_q    <= lv_d;
      lv_ok_q <= lv_ok_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      first_q <= first_d;
      last_q  <= last_d;
    end
  end

  // output register and second-result slot: valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else if (out_free) begin
      if (pend_valid_q) begin
        out_valid_q  <= 1'b1;
        pend_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= take && r0_v;
        pend_valid_q <= take && r1_v;
      end
    end
  end

  // output register and second-result slot: payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_valid_q) begin
        out_q <= pend_q;
      end else if (take && r0_v) begin
        out_q  <= r0;
        pend_q <= r1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `J1708_ASSERT(a_pend_behind_out, pend_valid_q |-> out_valid_q)
  `J1708_ASSERT(a_pend_last_order, pend_valid_q |-> (!out_q.last && pend_q.last))
  `J1708_ASSERT(a_byte_len_index,
    (out_valid_q && out_q.kind == KIND_BYTE) |->
      (out_q.msg_length == LEN_BITS'(out_q.byte_index) + LEN_BITS'(1)))

endmodule

// ----- rtl/core/j1708_message_framer_core.sv -----
// ----------------------------------------------------------------------------
// j1708_message_framer_core
// Frames J1708 messages from UART receiver events: echoes stored bytes,
// gives a verdict per message and reports inter-message gaps.
//
//   channel   direction  handshake            payload
//   in        input      in_valid_i/stall_o   in_item_t  (receiver event)
//   out       output     out_valid_o/stall_i  out_item_t (framer result)
//   apb       input      psel/penable/pready  bit_width_q8, message_break
//
// One event is taken per cycle while in_stall_o is low; its first result
// passes through the front register, the queue and the back-end output register.
// An event giving two results holds the back end while the second result
// leaves through the output register.
// Reset clears the phase machine, message state, queue and result valids.
// A stalled output fills the four-entry queue, after which in_stall_o rises.
// ----------------------------------------------------------------------------
module j1708_message_framer_core
  import j1708mf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  in_item_t                 in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output out_item_t                out_data_o
);

  gap_cfg_t gap_cfg;
  logic     q_push;
  cmd_t     q_push_data;
  logic     q_full;
  logic     q_pop;
  cmd_t     q_pop_data;
  logic     q_empty;

  // configuration registers
  j1708mf_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .gap_cfg_o (gap_cfg)
  );

  // event decode
  j1708mf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data),
    .q_full_i   (q_full)
  );

  // decoupling queue
  j1708mf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // framing engine
  j1708mf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gap_cfg_i   (gap_cfg),
    .q_valid_i   (!q_empty),
    .q_data_i    (q_pop_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
